@@ design/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the 2D k-means clustering block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmc_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int MAX_CLASSES     = 16;
   localparam int MAX_POINTS      = 1024;
   localparam int CLASS_WIDTH     = 4;
   localparam int INDEX_WIDTH     = 10;
   localparam int ITER_WIDTH      = 8;
   localparam int CLASS_CNT_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_POINT  = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic KIND_MEAN  = 1'b0;
   localparam logic KIND_CLASS = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITER  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLASS = 8'd1;

   typedef struct packed {
      logic [1:0]                    mode;
      logic [INDEX_WIDTH-1:0]        index;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic                          final_point;
   } req_type;

   typedef struct packed {
      logic                          kind;
      logic [CLASS_WIDTH-1:0]        class_id;
      logic signed [COORD_WIDTH-1:0] mean_x;
      logic signed [COORD_WIDTH-1:0] mean_y;
      logic                          end_of_run;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } point_type;

endpackage

`default_nettype wire

@@ design/kmeans_cluster_2d_top.sv @@
// ----------------------------------------------------------------------------
// kmeans_cluster_2d_top
// Lloyd k-means clustering of 2D fixed-point points with a small sequencer.
// ----------------------------------------------------------------------------
// A point read replies on the cycle after the transfer. A point marked
// final_point starts a run: each round walks every point through the
// assignment (one shared squaring unit, used once per point and class), then
// the serial divider, with an SW-bit numerator, forms x then y for each
// non-empty class, where SW = 16 + clog2(MAX_POINTS+1); after the last round
// the k centroids follow on consecutive cycles. busy stays high for the whole
// run. Results carry a strobe and cannot be held off by the receiver.
`default_nettype none

module kmeans_cluster_2d_top #(
   parameter int MAX_POINTS = kmc_pkg::MAX_POINTS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  kmc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output kmc_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [kmc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [kmc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int CW   = kmc_pkg::COORD_WIDTH;
   localparam int NCL  = kmc_pkg::MAX_CLASSES;
   localparam int CIW  = kmc_pkg::CLASS_WIDTH;
   localparam int KW   = $clog2(NCL + 1);
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int SW   = CW + CNTW;
   localparam int DSTW = 2 * CW + 1;
   localparam int ITW  = kmc_pkg::ITER_WIDTH;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_QUERY  = 9'b000000010,
      S_READ   = 9'b000000100,
      S_DSTART = 9'b000001000,
      S_DWAIT  = 9'b000010000,
      S_ACC    = 9'b000100000,
      S_VSTART = 9'b001000000,
      S_VWAIT  = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [ITW-1:0]            iter_ff;
   logic [kmc_pkg::CLASS_CNT_WIDTH-1:0] class_cnt_ff;
   logic [CNTW-1:0]           loaded_ff, n_ff, clustered_ff;
   logic [AW-1:0]             p_ff;
   logic [CIW-1:0]            c_ff, best_c_ff;
   logic [KW-1:0]             k_ff;
   logic [ITW-1:0]            it_ff, rounds_ff;
   logic                      axis_ff;
   logic                      q_hit_ff;
   logic [DSTW-1:0]           best_d_ff;

   logic [2*CW-1:0]           pmem [MAX_POINTS];
   logic [CIW-1:0]            amem [MAX_POINTS];
   kmc_pkg::point_type        pdata_ff;
   logic [CIW-1:0]            qdata_ff;
   logic signed [CW-1:0]      cen_x_ff [NCL];
   logic signed [CW-1:0]      cen_y_ff [NCL];
   logic signed [SW-1:0]      sum_x_ff [NCL];
   logic signed [SW-1:0]      sum_y_ff [NCL];
   logic [CNTW-1:0]           cnt_ff   [NCL];

   logic                      accept, full, run_go, class_last, point_last, round_last;
   logic                      adv, round_start, dist_done, div_done, div_start;
   logic [CNTW-1:0]           n_new;
   logic [KW-1:0]             k_eff;
   logic [ITW-1:0]            r_eff;
   logic [31:0]               idx_wide;
   logic [DSTW-1:0]           distance;
   logic signed [CW-1:0]      quo;
   kmc_pkg::point_type        cen_sel;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign idx_wide  = 32'(req_data.index);
   assign full      = (loaded_ff == CNTW'(MAX_POINTS));
   assign n_new     = full ? loaded_ff : loaded_ff + CNTW'(1);
   assign run_go    = accept && req_data.mode == kmc_pkg::MODE_POINT && req_data.final_point;

   // class count 0 acts as 1, too large acts as the maximum
   assign k_eff = (class_cnt_ff == '0) ? KW'(1) :
                  (32'(class_cnt_ff) > 32'(NCL)) ? KW'(NCL) : KW'(class_cnt_ff);
   assign r_eff = (iter_ff == '0) ? ITW'(1) : iter_ff;

   assign class_last = (KW'(c_ff) + KW'(1)) == k_ff;
   assign point_last = (CNTW'(p_ff) + CNTW'(1)) == n_ff;
   assign round_last = (9'(it_ff) + 9'd1) == 9'(rounds_ff);

   assign div_start   = (state_ff == S_VSTART) && (cnt_ff[c_ff] != '0);
   assign adv         = ((state_ff == S_VSTART) && (cnt_ff[c_ff] == '0)) ||
                        ((state_ff == S_VWAIT) && div_done && axis_ff);
   assign round_start = run_go || (adv && class_last && !round_last);

   assign cen_sel.x = cen_x_ff[c_ff];
   assign cen_sel.y = cen_y_ff[c_ff];

   kmc_sqdist u_sqdist (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DSTART),
      .pt       (pdata_ff),
      .cen      (cen_sel),
      .done     (dist_done),
      .distance (distance)
   );

   kmc_divider #(
      .NUM_W (SW),
      .DEN_W (CNTW),
      .QUO_W (CW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (axis_ff ? sum_y_ff[c_ff] : sum_x_ff[c_ff]),
      .den   (cnt_ff[c_ff]),
      .done  (div_done),
      .quo   (quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (run_go) state_in = S_READ;
            else if (accept && req_data.mode == kmc_pkg::MODE_QUERY) state_in = S_QUERY;
         end
         S_QUERY:  state_in = S_IDLE;
         S_READ:   state_in = S_DSTART;
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (dist_done) state_in = class_last ? S_ACC : S_DSTART;
         end
         S_ACC:    state_in = point_last ? S_VSTART : S_READ;
         S_VSTART: begin
            if (div_start) state_in = S_VWAIT;
         end
         S_VWAIT: begin
            if (div_done && !axis_ff) state_in = S_VSTART;
         end
         S_EMIT: begin
            if (class_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (adv) begin
         if (!class_last) state_in = S_VSTART;
         else if (!round_last) state_in = S_READ;
         else state_in = S_EMIT;
      end
   end

   // sequencer counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= ITW'(1);
         class_cnt_ff <= kmc_pkg::CLASS_CNT_WIDTH'(1);
         loaded_ff    <= '0;
         clustered_ff <= '0;
         n_ff         <= '0;
         p_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= KW'(1);
         it_ff        <= '0;
         rounds_ff    <= ITW'(1);
         axis_ff      <= 1'b0;
         q_hit_ff     <= 1'b0;
         best_c_ff    <= '0;
         best_d_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               kmc_pkg::CSR_ITER:  iter_ff      <= csr_wdata[ITW-1:0];
               kmc_pkg::CSR_CLASS: class_cnt_ff <= csr_wdata[kmc_pkg::CLASS_CNT_WIDTH-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_data.mode == kmc_pkg::MODE_POINT && !full)
                  loaded_ff <= loaded_ff + CNTW'(1);
               if (run_go) begin
                  n_ff      <= n_new;
                  k_ff      <= k_eff;
                  rounds_ff <= r_eff;
                  it_ff     <= '0;
                  p_ff      <= '0;
               end
               if (accept && req_data.mode == kmc_pkg::MODE_QUERY)
                  q_hit_ff <= idx_wide < 32'(clustered_ff);
            end
            S_READ: c_ff <= '0;
            S_DWAIT: begin
               if (dist_done) begin
                  if (c_ff == '0 || distance < best_d_ff) begin
                     best_c_ff <= c_ff;
                     best_d_ff <= distance;
                  end
                  if (!class_last) c_ff <= c_ff + CIW'(1);
               end
            end
            S_ACC: begin
               if (!point_last) p_ff <= p_ff + AW'(1);
               else begin
                  c_ff    <= '0;
                  axis_ff <= 1'b0;
               end
            end
            S_VWAIT: begin
               if (div_done) axis_ff <= ~axis_ff;
            end
            S_EMIT: c_ff <= c_ff + CIW'(1);
            default: ;
         endcase
         if (adv) begin
            if (!class_last) c_ff <= c_ff + CIW'(1);
            else if (!round_last) begin
               it_ff <= it_ff + ITW'(1);
               p_ff  <= '0;
            end else begin
               c_ff         <= '0;
               clustered_ff <= n_ff;
               loaded_ff    <= '0;
            end
         end
      end
   end

   // point and assignment memories
   always_ff @(posedge clock) begin
      if (accept && req_data.mode == kmc_pkg::MODE_POINT && !full)
         pmem[loaded_ff[AW-1:0]] <= {req_data.coord_x, req_data.coord_y};
      pdata_ff <= pmem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ACC) amem[p_ff] <= best_c_ff;
      qdata_ff <= amem[idx_wide[AW-1:0]];
   end

   // centroids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCL; i++) begin
            cen_x_ff[i] <= '0;
            cen_y_ff[i] <= '0;
         end
      end else if (accept && req_data.mode == kmc_pkg::MODE_LOAD &&
                   idx_wide < 32'(NCL)) begin
         cen_x_ff[req_data.index[CIW-1:0]] <= req_data.coord_x;
         cen_y_ff[req_data.index[CIW-1:0]] <= req_data.coord_y;
      end else if (state_ff == S_VWAIT && div_done) begin
         if (axis_ff) cen_y_ff[c_ff] <= quo;
         else         cen_x_ff[c_ff] <= quo;
      end
   end

   // member sums and counts, accumulated as each point gets its class
   always_ff @(posedge clock) begin
      if (round_start) begin
         for (int i = 0; i < NCL; i++) begin
            sum_x_ff[i] <= '0;
            sum_y_ff[i] <= '0;
            cnt_ff[i]   <= '0;
         end
      end else if (state_ff == S_ACC) begin
         sum_x_ff[best_c_ff] <= sum_x_ff[best_c_ff] + SW'(pdata_ff.x);
         sum_y_ff[best_c_ff] <= sum_y_ff[best_c_ff] + SW'(pdata_ff.y);
         cnt_ff[best_c_ff]   <= cnt_ff[best_c_ff] + CNTW'(1);
      end
   end

   always_comb begin
      rsp_valid = (state_ff == S_QUERY) || (state_ff == S_EMIT);
      if (state_ff == S_QUERY) begin
         rsp_data.kind       = kmc_pkg::KIND_CLASS;
         rsp_data.class_id   = q_hit_ff ? qdata_ff : '0;
         rsp_data.mean_x     = '0;
         rsp_data.mean_y     = '0;
         rsp_data.end_of_run = 1'b1;
      end else begin
         rsp_data.kind       = kmc_pkg::KIND_MEAN;
         rsp_data.class_id   = c_ff;
         rsp_data.mean_x     = cen_x_ff[c_ff];
         rsp_data.mean_y     = cen_y_ff[c_ff];
         rsp_data.end_of_run = class_last;
      end
   end

endmodule

`default_nettype wire

@@ design/kmc_sqdist.sv @@
// ----------------------------------------------------------------------------
// kmc_sqdist
// Squared euclidean distance unit, one shared multiplier used for x then y.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_sqdist (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  kmc_pkg::point_type          pt,
   input  kmc_pkg::point_type          cen,
   output logic                        done,
   output logic [2*kmc_pkg::COORD_WIDTH:0] distance
);

   localparam int CW = kmc_pkg::COORD_WIDTH;

   typedef enum logic [3:0] {
      SD_IDLE = 4'b0001,
      SD_MULX = 4'b0010,
      SD_MULY = 4'b0100,
      SD_ADD  = 4'b1000
   } sd_state_type;

   sd_state_type      state_ff, state_in;
   logic [CW-1:0]     dx_ff, dy_ff;
   logic [2*CW-1:0]   sqx_ff, sqy_ff;
   logic [2*CW:0]     dist_ff;
   logic              done_ff;
   logic signed [CW:0] ex, ey;
   logic [CW-1:0]     op;
   logic [2*CW-1:0]   prod;

   assign ex   = {pt.x[CW-1], pt.x} - {cen.x[CW-1], cen.x};
   assign ey   = {pt.y[CW-1], pt.y} - {cen.y[CW-1], cen.y};
   assign op   = (state_ff == SD_MULX) ? dx_ff : dy_ff;
   assign prod = op * op;

   always_comb begin
      unique case (state_ff)
         SD_IDLE: state_in = start ? SD_MULX : SD_IDLE;
         SD_MULX: state_in = SD_MULY;
         SD_MULY: state_in = SD_ADD;
         SD_ADD:  state_in = SD_IDLE;
         default: state_in = SD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == SD_ADD);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SD_IDLE && start) begin
         // magnitude of the difference always fits the coordinate width unsigned
         dx_ff <= ex[CW] ? CW'(-ex) : ex[CW-1:0];
         dy_ff <= ey[CW] ? CW'(-ey) : ey[CW-1:0];
      end
      if (state_ff == SD_MULX) sqx_ff <= prod;
      if (state_ff == SD_MULY) sqy_ff <= prod;
      if (state_ff == SD_ADD)  dist_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   assign done     = done_ff;
   assign distance = dist_ff;

endmodule

`default_nettype wire

@@ design/kmc_divider.sv @@
// ----------------------------------------------------------------------------
// kmc_divider
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 11,
   parameter int QUO_W = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire signed [NUM_W-1:0]   num,
   input  wire        [DEN_W-1:0]   den,
   output logic                     done,
   output logic signed [QUO_W-1:0]  quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   q_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               neg_ff;
   logic [DEN_W:0]     rem_sh;
   logic               fits;
   logic [NUM_W-1:0]   q_signed;

   assign rem_sh   = {rem_ff, q_ff[NUM_W-1]};
   assign fits     = rem_sh >= {1'b0, den_ff};
   assign q_signed = neg_ff ? -q_ff : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         q_ff   <= num[NUM_W-1] ? -num : num;
         neg_ff <= num[NUM_W-1];
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         q_ff   <= {q_ff[NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = q_signed[QUO_W-1:0];

endmodule

`default_nettype wire
